// ===== sv/gpio_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO package
// Operation codes, register offsets, pin mode codes and the types shared
// between the GPIO port modules.
// ----------------------------------------------------------------------------
package gpio_pkg;

   localparam int NUM_PINS_DEFAULT = 32;
   localparam int NUM_PINS_MAX     = 32;
   localparam int NUM_TRIG         = 4;
   localparam int INFO_WIDTH       = 10;

   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 104;

   // Word kinds carried on req_tuser.
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Pin modes.
   localparam logic [1:0] MODE_INPUT     = 2'd0;
   localparam logic [1:0] MODE_PUSH_PULL = 2'd1;
   localparam logic [1:0] MODE_OD_HIGH   = 2'd2;
   localparam logic [1:0] MODE_OD_LOW    = 2'd3;

   // Trigger kinds, in the order of their enable and status registers.
   localparam int TRIG_RISE = 0;
   localparam int TRIG_FALL = 1;
   localparam int TRIG_HIGH = 2;
   localparam int TRIG_LOW  = 3;

   // Register offsets.
   localparam logic [10:0] ADDR_INFO     = 11'h000;
   localparam logic [10:0] ADDR_CFG      = 11'h004;
   localparam logic [10:0] ADDR_MODE0    = 11'h008;
   localparam logic [10:0] ADDR_MODE1    = 11'h00C;
   localparam logic [10:0] ADDR_EN       = 11'h080;
   localparam logic [10:0] ADDR_IN       = 11'h100;
   localparam logic [10:0] ADDR_OUT      = 11'h180;
   localparam logic [10:0] ADDR_SET      = 11'h200;
   localparam logic [10:0] ADDR_CLR      = 11'h280;
   localparam logic [10:0] ADDR_TGL      = 11'h300;
   localparam logic [10:0] ADDR_TEN_RISE = 11'h380;
   localparam logic [10:0] ADDR_TEN_FALL = 11'h400;
   localparam logic [10:0] ADDR_TEN_HIGH = 11'h480;
   localparam logic [10:0] ADDR_TEN_LOW  = 11'h500;
   localparam logic [10:0] ADDR_STATUS   = 11'h580;
   localparam logic [10:0] ADDR_TST_RISE = 11'h600;
   localparam logic [10:0] ADDR_TST_FALL = 11'h680;
   localparam logic [10:0] ADDR_TST_HIGH = 11'h700;
   localparam logic [10:0] ADDR_TST_LOW  = 11'h780;

   typedef struct packed {
      logic [1:0]  operation;
      logic [10:0] address;
      logic [31:0] write_data;
      logic [31:0] pins_in;
   } gpio_cmd_type;

   // State that sets the pad drivers.
   typedef struct packed {
      logic [63:0] pin_modes;
      logic [31:0] output_value;
   } gpio_drive_type;

   function automatic logic [31:0] live_pin_bits(input int n);
      logic [31:0] ones;
      ones = '1;
      return ones >> (6'(NUM_PINS_MAX - n));
   endfunction

   function automatic logic [63:0] mode_mask(input int n);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < NUM_PINS_MAX; i++) begin
         if (i < n) begin
            m[2*i +: 2] = 2'b11;
         end
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// ===== sv/gpio_pad.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO pad drivers
// Turns the pin modes and the output register into driven levels and
// driver enables for each pin.
// ----------------------------------------------------------------------------
module gpio_pad (
   input  gpio_pkg::gpio_drive_type drive,
   output logic [31:0]              pad_out,
   output logic [31:0]              pad_drive_enable
);
   import gpio_pkg::*;

   always_comb begin
      pad_out          = '0;
      pad_drive_enable = '0;
      for (int p = 0; p < NUM_PINS_MAX; p++) begin
         case (drive.pin_modes[2*p +: 2])
            MODE_PUSH_PULL: begin
               pad_drive_enable[p] = 1'b1;
               pad_out[p]          = drive.output_value[p];
            end
            MODE_OD_HIGH: begin
               pad_drive_enable[p] = drive.output_value[p];
               pad_out[p]          = drive.output_value[p];
            end
            MODE_OD_LOW: begin
               // Drives low while the output bit is clear; the level is 0.
               pad_drive_enable[p] = ~drive.output_value[p];
            end
            default: begin
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== sv/gpio_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO register file
// Holds the bus-mapped registers, applies at most one read, write or sample tick
// per committed word and reports the updated drive state and interrupt.
// ----------------------------------------------------------------------------
module gpio_regs #(
   parameter int NUM_PINS = gpio_pkg::NUM_PINS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     commit,
   input  gpio_pkg::gpio_cmd_type   cmd,
   output logic [31:0]              read_data,
   output gpio_pkg::gpio_drive_type drive_in,
   output logic                     irq_in
);
   import gpio_pkg::*;

   localparam logic [31:0] LIVE_BITS = live_pin_bits(NUM_PINS);
   localparam logic [63:0] MODE_MASK = mode_mask(NUM_PINS);
   localparam logic [31:0] INFO_WORD = 32'(NUM_PINS % (1 << INFO_WIDTH));

   logic [63:0] pin_modes_ff, pin_modes_in;
   logic [31:0] sample_en_ff, sample_en_in;
   logic [31:0] input_value_ff, input_value_in;
   logic [31:0] output_value_ff, output_value_in;
   logic [1:0]  global_cfg_ff, global_cfg_in;
   logic [31:0] trig_en_ff [NUM_TRIG];
   logic [31:0] trig_en_in [NUM_TRIG];
   logic [31:0] trig_st_ff [NUM_TRIG];
   logic [31:0] trig_st_in [NUM_TRIG];
   logic [31:0] combined_ff, combined_in;

   logic [31:0] wdata_masked;
   logic [31:0] new_level;
   logic [31:0] events [NUM_TRIG];
   logic [31:0] any_hit;

   assign wdata_masked = cmd.write_data & LIVE_BITS;

   // Sampled levels and detected events for a tick.
   always_comb begin
      new_level = (input_value_ff & ~sample_en_ff) | (cmd.pins_in & sample_en_ff);
      events[TRIG_RISE] = ~input_value_ff & new_level & sample_en_ff;
      events[TRIG_FALL] = input_value_ff & ~new_level & sample_en_ff;
      events[TRIG_HIGH] = new_level & sample_en_ff;
      events[TRIG_LOW]  = ~new_level & sample_en_ff;
   end

   always_comb begin
      pin_modes_in    = pin_modes_ff;
      sample_en_in    = sample_en_ff;
      input_value_in  = input_value_ff;
      output_value_in = output_value_ff;
      global_cfg_in   = global_cfg_ff;
      trig_en_in      = trig_en_ff;
      trig_st_in      = trig_st_ff;
      combined_in     = combined_ff;
      read_data       = '0;
      any_hit         = '0;

      case (cmd.operation)
         OP_READ: begin
            case (cmd.address)
               ADDR_INFO:     read_data = INFO_WORD;
               ADDR_CFG:      read_data = {30'b0, global_cfg_ff};
               ADDR_MODE0:    read_data = pin_modes_ff[31:0];
               ADDR_MODE1:    read_data = pin_modes_ff[63:32];
               ADDR_EN:       read_data = sample_en_ff;
               ADDR_IN:       read_data = input_value_ff;
               ADDR_OUT:      read_data = output_value_ff;
               ADDR_TEN_RISE: read_data = trig_en_ff[TRIG_RISE];
               ADDR_TEN_FALL: read_data = trig_en_ff[TRIG_FALL];
               ADDR_TEN_HIGH: read_data = trig_en_ff[TRIG_HIGH];
               ADDR_TEN_LOW:  read_data = trig_en_ff[TRIG_LOW];
               ADDR_STATUS:   read_data = combined_ff;
               ADDR_TST_RISE: read_data = trig_st_ff[TRIG_RISE];
               ADDR_TST_FALL: read_data = trig_st_ff[TRIG_FALL];
               ADDR_TST_HIGH: read_data = trig_st_ff[TRIG_HIGH];
               ADDR_TST_LOW:  read_data = trig_st_ff[TRIG_LOW];
               default:       read_data = '0;
            endcase
         end
         OP_WRITE: begin
            case (cmd.address)
               ADDR_CFG:      global_cfg_in = cmd.write_data[1:0];
               ADDR_MODE0:    pin_modes_in = {pin_modes_ff[63:32], cmd.write_data} & MODE_MASK;
               ADDR_MODE1:    pin_modes_in = {cmd.write_data, pin_modes_ff[31:0]} & MODE_MASK;
               ADDR_EN:       sample_en_in = wdata_masked;
               ADDR_OUT:      output_value_in = wdata_masked;
               ADDR_SET:      output_value_in = output_value_ff | wdata_masked;
               ADDR_CLR:      output_value_in = output_value_ff & ~wdata_masked;
               ADDR_TGL:      output_value_in = output_value_ff ^ wdata_masked;
               ADDR_TEN_RISE: trig_en_in[TRIG_RISE] = wdata_masked;
               ADDR_TEN_FALL: trig_en_in[TRIG_FALL] = wdata_masked;
               ADDR_TEN_HIGH: trig_en_in[TRIG_HIGH] = wdata_masked;
               ADDR_TEN_LOW:  trig_en_in[TRIG_LOW] = wdata_masked;
               ADDR_STATUS:   combined_in = combined_ff & ~cmd.write_data;
               ADDR_TST_RISE: trig_st_in[TRIG_RISE] = trig_st_ff[TRIG_RISE] & ~cmd.write_data;
               ADDR_TST_FALL: trig_st_in[TRIG_FALL] = trig_st_ff[TRIG_FALL] & ~cmd.write_data;
               ADDR_TST_HIGH: trig_st_in[TRIG_HIGH] = trig_st_ff[TRIG_HIGH] & ~cmd.write_data;
               ADDR_TST_LOW:  trig_st_in[TRIG_LOW] = trig_st_ff[TRIG_LOW] & ~cmd.write_data;
               default: begin
               end
            endcase
         end
         OP_TICK: begin
            for (int k = 0; k < NUM_TRIG; k++) begin
               trig_st_in[k] = trig_st_ff[k] | (events[k] & trig_en_ff[k]);
               any_hit       = any_hit | (events[k] & trig_en_ff[k]);
            end
            combined_in    = combined_ff | any_hit;
            input_value_in = new_level & LIVE_BITS;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_modes_ff    <= '0;
         sample_en_ff    <= '0;
         input_value_ff  <= '0;
         output_value_ff <= '0;
         global_cfg_ff   <= '0;
         combined_ff     <= '0;
         for (int k = 0; k < NUM_TRIG; k++) begin
            trig_en_ff[k] <= '0;
            trig_st_ff[k] <= '0;
         end
      end else if (commit) begin
         pin_modes_ff    <= pin_modes_in;
         sample_en_ff    <= sample_en_in;
         input_value_ff  <= input_value_in;
         output_value_ff <= output_value_in;
         global_cfg_ff   <= global_cfg_in;
         combined_ff     <= combined_in;
         trig_en_ff      <= trig_en_in;
         trig_st_ff      <= trig_st_in;
      end
   end

   assign drive_in.pin_modes    = pin_modes_in;
   assign drive_in.output_value = output_value_in;
   assign irq_in                = |combined_in;

endmodule
`default_nettype wire

// ===== sv/gpio_port_with_edge_level_interrupts.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A word taken on req passes through the command register and then the
// result register before it appears on rsp.
// Throughput: one word per cycle, limited only by rsp_tready; the register
// update and pad decode fit in the single stage between the two registers.
// Reset: synchronous, active high; clears both stage valids and every bus-mapped register.
// ----------------------------------------------------------------------------
// GPIO port with edge and level interrupts
// GPIO of up to 32 pins with bus-mapped registers, pin sampling on ticks, per-pin
// drive modes and sticky rise, fall, level-high and level-low status.
// ----------------------------------------------------------------------------
module gpio_port_with_edge_level_interrupts #(
   parameter int NUM_PINS = gpio_pkg::NUM_PINS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: operation[1:0].
   input  logic [1:0]                          req_tuser,
   // Fields from bit 0: address[10:0], write_data[31:0], pins_in[31:0], zero pad.
   input  logic [gpio_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: read_data[31:0], pad_out[31:0], pad_drive_enable[31:0],
   // irq, zero pad.
   output logic [gpio_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import gpio_pkg::*;

   logic                     cmd_valid_ff, cmd_valid_in;
   gpio_cmd_type             cmd_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff;

   logic                     rsp_advance;
   logic                     commit;
   logic [31:0]              read_data;
   gpio_drive_type           drive_in;
   logic                     irq_in;
   logic [31:0]              pad_out;
   logic [31:0]              pad_drive_enable;

   // The result register frees when empty or taken; the command register
   // moves on whenever the result register can take its word.
   assign rsp_advance  = ~rsp_valid_ff | rsp_tready;
   assign req_tready   = ~cmd_valid_ff | rsp_advance;
   assign commit       = cmd_valid_ff & rsp_advance;
   assign cmd_valid_in = req_tready ? req_tvalid : cmd_valid_ff;
   assign rsp_valid_in = rsp_advance ? cmd_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff.operation  <= req_tuser;
         cmd_ff.address    <= req_tdata[10:0];
         cmd_ff.write_data <= req_tdata[42:11];
         cmd_ff.pins_in    <= req_tdata[74:43];
      end
      if (commit) begin
         rsp_data_ff <= {7'b0, irq_in, pad_drive_enable, pad_out, read_data};
      end
   end

   gpio_regs #(
      .NUM_PINS (NUM_PINS)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .commit    (commit),
      .cmd       (cmd_ff),
      .read_data (read_data),
      .drive_in  (drive_in),
      .irq_in    (irq_in)
   );

   gpio_pad u_pad (
      .drive            (drive_in),
      .pad_out          (pad_out),
      .pad_drive_enable (pad_drive_enable)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== tb/sv/gpio_port_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO port checker
// Watches the request and response streams of the GPIO port. It keeps its
// own copy of the register file, applies every accepted request word to it,
// and compares each response word with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module gpio_port_checker #(
   parameter int NUM_PINS = gpio_pkg::NUM_PINS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [1:0]                       req_tuser,
   input  logic [gpio_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [gpio_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                               fail_count,
   output int                               pending,
   output int                               results_checked,
   output int                               irq_results
);
   import gpio_pkg::*;

   localparam logic [31:0] LIVE_PINS = 32'hFFFF_FFFF >> (32 - NUM_PINS);

   typedef struct packed {
      logic [31:0] read_data;
      logic [31:0] pad_out;
      logic [31:0] pad_drive_enable;
      logic        irq;
   } port_result_type;

   logic [63:0]     pin_modes;
   logic [31:0]     sample_en;
   logic [31:0]     in_level;
   logic [31:0]     out_level;
   logic [1:0]      cfg_bits;
   logic [31:0]     trig_en [NUM_TRIG];
   logic [31:0]     trig_st [NUM_TRIG];
   logic [31:0]     any_st;
   port_result_type due_results [$];
   port_result_type want;

   task automatic report_fault(input string what, input logic [31:0] got,
                               input logic [31:0] want_v);
      fail_count++;
      $display("mismatch at %0t: %s is %h, predicted %h", $time, what, got, want_v);
   endtask

   // Applies one request word to the register copy and queues the response.
   task automatic apply_word(input logic [1:0] op, input logic [10:0] addr,
                             input logic [31:0] wd, input logic [31:0] pins);
      logic [31:0]     en;
      logic [31:0]     nv;
      logic [31:0]     hit;
      logic [31:0]     ev [NUM_TRIG];
      port_result_type res;
      res = '0;
      case (op)
         OP_READ: begin
            case (addr)
               ADDR_INFO:     res.read_data = 32'(NUM_PINS) & 32'h3FF;
               ADDR_CFG:      res.read_data = {30'd0, cfg_bits};
               ADDR_MODE0:    res.read_data = pin_modes[31:0];
               ADDR_MODE1:    res.read_data = pin_modes[63:32];
               ADDR_EN:       res.read_data = sample_en;
               ADDR_IN:       res.read_data = in_level;
               ADDR_OUT:      res.read_data = out_level;
               ADDR_TEN_RISE: res.read_data = trig_en[TRIG_RISE];
               ADDR_TEN_FALL: res.read_data = trig_en[TRIG_FALL];
               ADDR_TEN_HIGH: res.read_data = trig_en[TRIG_HIGH];
               ADDR_TEN_LOW:  res.read_data = trig_en[TRIG_LOW];
               ADDR_STATUS:   res.read_data = any_st;
               ADDR_TST_RISE: res.read_data = trig_st[TRIG_RISE];
               ADDR_TST_FALL: res.read_data = trig_st[TRIG_FALL];
               ADDR_TST_HIGH: res.read_data = trig_st[TRIG_HIGH];
               ADDR_TST_LOW:  res.read_data = trig_st[TRIG_LOW];
               default:       res.read_data = '0;
            endcase
         end
         OP_WRITE: begin
            case (addr)
               ADDR_CFG:      cfg_bits = wd[1:0];
               ADDR_MODE0:    pin_modes[31:0] = wd;
               ADDR_MODE1:    pin_modes[63:32] = wd;
               ADDR_EN:       sample_en = wd & LIVE_PINS;
               ADDR_OUT:      out_level = wd & LIVE_PINS;
               ADDR_SET:      out_level = out_level | (wd & LIVE_PINS);
               ADDR_CLR:      out_level = out_level & ~(wd & LIVE_PINS);
               ADDR_TGL:      out_level = out_level ^ (wd & LIVE_PINS);
               ADDR_TEN_RISE: trig_en[TRIG_RISE] = wd & LIVE_PINS;
               ADDR_TEN_FALL: trig_en[TRIG_FALL] = wd & LIVE_PINS;
               ADDR_TEN_HIGH: trig_en[TRIG_HIGH] = wd & LIVE_PINS;
               ADDR_TEN_LOW:  trig_en[TRIG_LOW]  = wd & LIVE_PINS;
               ADDR_STATUS:   any_st = any_st & ~wd;
               ADDR_TST_RISE: trig_st[TRIG_RISE] = trig_st[TRIG_RISE] & ~wd;
               ADDR_TST_FALL: trig_st[TRIG_FALL] = trig_st[TRIG_FALL] & ~wd;
               ADDR_TST_HIGH: trig_st[TRIG_HIGH] = trig_st[TRIG_HIGH] & ~wd;
               ADDR_TST_LOW:  trig_st[TRIG_LOW]  = trig_st[TRIG_LOW] & ~wd;
               default: ;
            endcase
            for (int p = NUM_PINS; p < 32; p++) begin
               pin_modes[2*p +: 2] = 2'b00;
            end
         end
         OP_TICK: begin
            en = sample_en & LIVE_PINS;
            nv = (in_level & ~en) | (pins & en);
            ev[TRIG_RISE] = ~in_level & nv & en;
            ev[TRIG_FALL] = in_level & ~nv & en;
            ev[TRIG_HIGH] = nv & en;
            ev[TRIG_LOW]  = ~nv & en;
            for (int k = 0; k < NUM_TRIG; k++) begin
               hit = ev[k] & trig_en[k] & LIVE_PINS;
               trig_st[k] = trig_st[k] | hit;
               any_st = any_st | hit;
            end
            in_level = nv & LIVE_PINS;
         end
         default: ;
      endcase
      for (int p = 0; p < NUM_PINS; p++) begin
         case (pin_modes[2*p +: 2])
            MODE_PUSH_PULL: begin
               res.pad_drive_enable[p] = 1'b1;
               res.pad_out[p] = out_level[p];
            end
            MODE_OD_HIGH: begin
               res.pad_drive_enable[p] = out_level[p];
               res.pad_out[p] = out_level[p];
            end
            MODE_OD_LOW: res.pad_drive_enable[p] = ~out_level[p];
            MODE_INPUT: ;
            default: ;
         endcase
      end
      res.irq = (any_st != '0);
      due_results.push_back(res);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pin_modes = '0;
         sample_en = '0;
         in_level  = '0;
         out_level = '0;
         cfg_bits  = '0;
         any_st    = '0;
         for (int k = 0; k < NUM_TRIG; k++) begin
            trig_en[k] = '0;
            trig_st[k] = '0;
         end
         due_results.delete();
         fail_count      = 0;
         results_checked = 0;
         irq_results     = 0;
      end else begin
         // The response is checked before the request of the same edge is
         // applied, so that a word can never be matched against itself.
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               report_fault("response word with nothing outstanding", rsp_tdata[31:0], '0);
            end else begin
               want = due_results.pop_front();
               if (rsp_tdata[31:0] !== want.read_data) begin
                  report_fault("read_data", rsp_tdata[31:0], want.read_data);
               end
               if (rsp_tdata[63:32] !== want.pad_out) begin
                  report_fault("pad_out", rsp_tdata[63:32], want.pad_out);
               end
               if (rsp_tdata[95:64] !== want.pad_drive_enable) begin
                  report_fault("pad_drive_enable", rsp_tdata[95:64], want.pad_drive_enable);
               end
               if (rsp_tdata[96] !== want.irq) begin
                  report_fault("irq", {31'd0, rsp_tdata[96]}, {31'd0, want.irq});
               end
               results_checked++;
               if (want.irq) begin
                  irq_results++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_word(req_tuser, req_tdata[10:0], req_tdata[42:11], req_tdata[74:43]);
         end
      end
      pending = due_results.size();
   end

endmodule

// ===== tb/sv/tb_gpio_port_with_edge_level_interrupts.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO port testbench
// Drives bus reads, bus writes, pin-sample ticks and no-op words into the GPIO
// port with random gaps and response stalls; a checker beside the port
// predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_gpio_port_with_edge_level_interrupts;
   import gpio_pkg::*;

   // The fourth word kind has no effect on the port.
   localparam logic [1:0] OP_IDLE = 2'd3;
   localparam int RANDOM_WORDS = 1900;
   localparam int CYCLE_LIMIT  = 1_000_000;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [1:0]             req_tuser  = OP_READ;
   // Fields from bit 0: address[10:0], write_data[31:0], pins_in[31:0], zero pad.
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // Fields from bit 0: read_data[31:0], pad_out[31:0], pad_drive_enable[31:0],
   // irq, zero pad.
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int fail_count;
   int pending;
   int results_checked;
   int irq_results;
   int n_read  = 0;
   int n_write = 0;
   int n_tick  = 0;
   int n_idle  = 0;
   int sink_hold = 0;
   int cycles    = 0;
   bit quiet     = 1'b0;

   logic [10:0] reg_map [19] = '{ADDR_INFO, ADDR_CFG, ADDR_MODE0, ADDR_MODE1, ADDR_EN,
                                 ADDR_IN, ADDR_OUT, ADDR_SET, ADDR_CLR, ADDR_TGL,
                                 ADDR_TEN_RISE, ADDR_TEN_FALL, ADDR_TEN_HIGH,
                                 ADDR_TEN_LOW, ADDR_STATUS, ADDR_TST_RISE,
                                 ADDR_TST_FALL, ADDR_TST_HIGH, ADDR_TST_LOW};

   gpio_port_with_edge_level_interrupts uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   gpio_port_checker #(
      .NUM_PINS (NUM_PINS_DEFAULT)
   ) watch (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tuser       (req_tuser),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked),
      .irq_results     (irq_results)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d words outstanding", cycles, pending);
         $display("FAIL gpio_port_with_edge_level_interrupts");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(8, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   always @(negedge clock) begin
      if (sink_hold > 0) begin
         rsp_tready <= 1'b0;
         sink_hold  <= sink_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 4) == 0) begin
            sink_hold <= gap_len();
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input logic [1:0] op, input logic [10:0] addr,
                            input logic [31:0] wd, input logic [31:0] pins);
      int gap;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'd0, pins, wd, addr};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      case (op)
         OP_READ:  n_read++;
         OP_WRITE: n_write++;
         OP_TICK:  n_tick++;
         default:  n_idle++;
      endcase
   endtask

   // Holds the request side off until every outstanding word has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      logic [31:0] wd;
      logic [31:0] pins;
      logic [31:0] last_pins;
      logic [10:0] addr;
      int          pick;
      last_pins = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(OP_READ,  ADDR_INFO,     '0,            '0);
      send_word(OP_WRITE, ADDR_CFG,      32'hFFFF_FFFF, '0);
      send_word(OP_READ,  ADDR_CFG,      '0,            '0);
      // Every mode appears on some pin in both halves.
      send_word(OP_WRITE, ADDR_MODE0,    32'hE4E4_E4E4, '0);
      send_word(OP_WRITE, ADDR_MODE1,    32'h1B1B_1B1B, '0);
      send_word(OP_WRITE, ADDR_OUT,      32'hFFFF_0000, '0);
      send_word(OP_WRITE, ADDR_SET,      32'h0000_FFFF, '0);
      send_word(OP_WRITE, ADDR_CLR,      32'hAAAA_AAAA, '0);
      send_word(OP_WRITE, ADDR_TGL,      32'hFFFF_FFFF, '0);
      send_word(OP_WRITE, ADDR_EN,       32'hFFFF_FFFF, '0);
      send_word(OP_WRITE, ADDR_TEN_RISE, 32'hFFFF_FFFF, '0);
      send_word(OP_WRITE, ADDR_TEN_FALL, 32'hFFFF_FFFF, '0);
      send_word(OP_WRITE, ADDR_TEN_HIGH, 32'hFFFF_FFFF, '0);
      send_word(OP_WRITE, ADDR_TEN_LOW,  32'hFFFF_FFFF, '0);
      send_word(OP_TICK,  ADDR_INFO,     '0,            32'hFFFF_FFFF);
      send_word(OP_TICK,  ADDR_INFO,     '0,            32'h0000_0000);
      send_word(OP_READ,  ADDR_TST_RISE, '0,            '0);
      // Per-type and combined status clear independently; the low level
      // still holds and sets the combined status again on the following tick.
      send_word(OP_WRITE, ADDR_TST_RISE, 32'hFFFF_FFFF, '0);
      send_word(OP_WRITE, ADDR_STATUS,   32'hFFFF_FFFF, '0);
      send_word(OP_TICK,  ADDR_INFO,     '0,            32'h0000_0000);
      send_word(OP_WRITE, ADDR_IN,       32'hFFFF_FFFF, '0);
      send_word(OP_READ,  ADDR_SET,      '0,            '0);
      send_word(OP_READ,  11'h382,       '0,            '0);
      send_word(OP_READ,  11'h7FC,       32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_IDLE,  ADDR_STATUS,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // Upper pins stop sampling and must keep their level.
      send_word(OP_WRITE, ADDR_EN,       32'h0000_FFFF, '0);
      send_word(OP_TICK,  ADDR_INFO,     '0,            32'hFFFF_0000);
      send_word(OP_READ,  ADDR_IN,       '0,            '0);
      drain();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 150 == 0) begin
            quiet = ($urandom_range(0, 3) == 0);
         end
         if (i == 600 || i == 1300) begin
            drain();
         end
         pick = $urandom_range(0, 99);
         wd   = $urandom();
         pins = $urandom();
         addr = reg_map[$urandom_range(0, 18)];
         if (pick < 32) begin
            case ($urandom_range(0, 3))
               0:       pins = last_pins ^ (32'd1 << $urandom_range(0, 31));
               1:       pins = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
               default: pins = $urandom();
            endcase
            last_pins = pins;
            send_word(OP_TICK, 11'($urandom_range(0, 2047)), wd, pins);
         end else if (pick < 64) begin
            // Sparse data lets write-one-to-clear leave some bits standing.
            if ($urandom_range(0, 3) == 0) begin
               wd = $urandom() & $urandom() & $urandom();
            end
            send_word(OP_WRITE, addr, wd, pins);
         end else if (pick < 92) begin
            send_word(OP_READ, addr, wd, pins);
         end else begin
            send_word(2'($urandom_range(0, 3)), 11'($urandom_range(0, 2047)), wd, pins);
         end
      end

      drain();
      repeat (10) @(posedge clock);
      $display("Run covered %0d reads, %0d writes, %0d sample ticks and %0d no-op words.",
               n_read, n_write, n_tick, n_idle);
      $display("%0d response words compared, %0d of them with the interrupt raised.",
               results_checked, irq_results);
      if (fail_count == 0) begin
         $display("PASS gpio_port_with_edge_level_interrupts");
      end else begin
         $display("%0d mismatches found", fail_count);
         $display("FAIL gpio_port_with_edge_level_interrupts");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/gpio_pkg.sv
sv/gpio_pad.sv
sv/gpio_regs.sv
sv/gpio_port_with_edge_level_interrupts.sv
tb/sv/gpio_port_checker.sv
tb/sv/tb_gpio_port_with_edge_level_interrupts.sv
